// File: hw/rtl/ftbg_pkg.sv
// Shared types, operation codes and constant tables of the fragment blend core.
package ftbg_pkg;

   // Number of register stages from the request capture to the response register.
   localparam int NUM_STAGES = 7;

   // Operation codes carried on the func field.
   localparam logic [1:0] FUNC_SPRITE  = 2'd0;
   localparam logic [1:0] FUNC_LINE    = 2'd1;
   localparam logic [1:0] FUNC_GOURAUD = 2'd2;

   // Bit position of the semi-transparency flag inside a texel.
   localparam int STP_POS = 15;

   // Channel ceiling, modulation rounding term and the fixed-point one.
   localparam logic [4:0]  CH_MAX   = 5'd31;
   localparam logic [12:0] ROUND_K  = 13'd52;
   localparam logic [8:0]  FRAC_ONE = 9'd256;

   // Gouraud corner colors, one row per channel (r, g, b), columns TL, TR, BL, BR.
   localparam logic [7:0] CORNER [3][4] = '{
      '{8'h00, 8'h08, 8'h08, 8'h00},
      '{8'h10, 8'h00, 8'h00, 8'h10},
      '{8'h7b, 8'h4a, 8'h52, 8'h5a}
   };

   // Sprite and line operands of one fragment.
   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] tex;
      logic [7:0]  mod_r;
      logic [7:0]  mod_g;
      logic [7:0]  mod_b;
      logic        semi;
      logic [14:0] dest;
   } frag_type;

   // Control that travels beside the divider and interpolator stages.
   typedef struct packed {
      logic        is_gour;
      logic        g_draw;
      logic        fx_zero;
      logic        fy_zero;
      logic [14:0] sl_pix;
      logic        sl_we;
   } side_type;

endpackage

// File: hw/rtl/fragment_texture_blend_gouraud_core.sv
// Top level of the fragment texture, blend and gouraud pipeline.
// This core takes one fragment beat per clock while req_stall is low and returns exactly
// one response beat for each, in order. The pipeline has seven register stages: request
// capture, three stages of the position dividers (three quotient bits each), two
// interpolation stages and the response register. Every stage has its own valid bit and
// loads whenever it is empty or its successor loads, so bubbles close up and a new
// fragment is accepted while a finished response waits; req_stall rises only when all
// seven stages hold work and rsp_stall is high. Sprite texels are modulated and
// optionally averaged with the destination, line pixels are a half blend with the fill
// color, and gouraud pixels interpolate four fixed corner colors; a transparent texel,
// a position outside the quad or an unused operation code gives a beat with
// write_enable low and a zero pixel.
module fragment_texture_blend_gouraud_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_texel_color,
   input  logic [7:0]  req_mod_r,
   input  logic [7:0]  req_mod_g,
   input  logic [7:0]  req_mod_b,
   input  logic        req_semi_enable,
   input  logic [14:0] req_dest_pixel,
   input  logic [8:0]  req_pos_x,
   input  logic [8:0]  req_pos_y,
   input  logic [8:0]  req_quad_w,
   input  logic [8:0]  req_quad_h,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_pixel_out,
   output logic        rsp_write_enable
);
   import ftbg_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] stage_load;

   frag_type   frag_in;
   frag_type   frag_ff;
   logic [8:0] px_ff;
   logic [8:0] py_ff;
   logic [8:0] qw_ff;
   logic [8:0] qh_ff;

   side_type   side_in [5];
   side_type   side_ff [5];

   logic [8:0]  den_x;
   logic [8:0]  den_y;
   logic [8:0]  quo_x;
   logic [8:0]  quo_y;
   logic [8:0]  fx;
   logic [8:0]  fy;
   logic [14:0] sl_pix;
   logic        sl_we;
   logic [14:0] g_pix;

   logic [14:0] pixel_in;
   logic        we_in;
   logic [14:0] pixel_ff;
   logic        we_ff;

   // A stage loads when it is empty or the stage after it loads.
   always_comb begin
      stage_load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_load[k] = !valid_ff[k] || stage_load[k+1];
      end
   end

   assign req_stall = !stage_load[0];

   // Valid bits move with their stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_load[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_load[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Request capture.
   always_comb begin
      frag_in.func  = req_func;
      frag_in.tex   = req_texel_color;
      frag_in.mod_r = req_mod_r;
      frag_in.mod_g = req_mod_g;
      frag_in.mod_b = req_mod_b;
      frag_in.semi  = req_semi_enable;
      frag_in.dest  = req_dest_pixel;
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         frag_ff <= frag_in;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         qw_ff   <= req_quad_w;
         qh_ff   <= req_quad_h;
      end
   end

   // Gouraud position ratios; a quad of width or height one forces the ratio to zero.
   assign den_x = qw_ff - 9'd1;
   assign den_y = qh_ff - 9'd1;

   ftbg_div_pipe u_div_x (
      .clock      (clock),
      .stage_load (stage_load[3:1]),
      .num        (px_ff),
      .den        (den_x),
      .quo        (quo_x)
   );

   ftbg_div_pipe u_div_y (
      .clock      (clock),
      .stage_load (stage_load[3:1]),
      .num        (py_ff),
      .den        (den_y),
      .quo        (quo_y)
   );

   ftbg_sprite_line u_sprite_line (
      .clock      (clock),
      .stage_load (stage_load[2:1]),
      .frag       (frag_ff),
      .pix        (sl_pix),
      .we         (sl_we)
   );

   assign fx = side_ff[2].fx_zero ? 9'd0 : quo_x;
   assign fy = side_ff[2].fy_zero ? 9'd0 : quo_y;

   ftbg_gouraud u_gouraud (
      .clock      (clock),
      .stage_load (stage_load[5:4]),
      .fx         (fx),
      .fy         (fy),
      .pix        (g_pix)
   );

   // Side control: built from the capture stage, joined by the sprite and line result.
   always_comb begin
      side_in[0].is_gour = (frag_ff.func == FUNC_GOURAUD);
      side_in[0].g_draw  = (px_ff < qw_ff) && (py_ff < qh_ff);
      side_in[0].fx_zero = (qw_ff <= 9'd1);
      side_in[0].fy_zero = (qh_ff <= 9'd1);
      side_in[0].sl_pix  = '0;
      side_in[0].sl_we   = 1'b0;
      side_in[1]         = side_ff[0];
      side_in[2]         = side_ff[1];
      side_in[2].sl_pix  = sl_pix;
      side_in[2].sl_we   = sl_we;
      side_in[3]         = side_ff[2];
      side_in[4]         = side_ff[3];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 5; k++) begin
         if (stage_load[k+1]) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // Response register: the gouraud result or the sprite and line result.
   always_comb begin
      if (side_ff[4].is_gour) begin
         pixel_in = side_ff[4].g_draw ? g_pix : 15'd0;
         we_in    = side_ff[4].g_draw;
      end else begin
         pixel_in = side_ff[4].sl_pix;
         we_in    = side_ff[4].sl_we;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[NUM_STAGES-1]) begin
         pixel_ff <= pixel_in;
         we_ff    <= we_in;
      end
   end

   assign rsp_valid        = valid_ff[NUM_STAGES-1];
   assign rsp_pixel_out    = pixel_ff;
   assign rsp_write_enable = we_ff;

   // A beat without a write carries a zero pixel.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_pixel_out == 15'd0)
      else $error("response without write carries a nonzero pixel");

   // While the response side takes beats, the request side is never held off.
   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while the response side is free");

   // An empty pipeline never stalls the request side.
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      valid_ff == '0 |-> !req_stall)
      else $error("empty pipeline stalls the request side");

   // A beat held in the last interpolation stage is not lost while the output blocks.
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-2] && !stage_load[NUM_STAGES-1] |=> valid_ff[NUM_STAGES-2])
      else $error("held beat dropped from the pipeline");

endmodule

// File: hw/rtl/ftbg_div_pipe.sv
// Three-stage restoring divider that gives floor(num * 256 / den) for num <= den.
module ftbg_div_pipe (
   input  logic       clock,
   input  logic [2:0] stage_load,
   input  logic [8:0] num,
   input  logic [8:0] den,
   output logic [8:0] quo
);
   import ftbg_pkg::*;

   localparam int STEPS_PER_STAGE = 3;

   typedef struct packed {
      logic [8:0] rem;
      logic [8:0] quo;
   } div_state_type;

   // Three quotient bits; the first step shifts in lead, the rest shift in zero.
   function automatic div_state_type div_group(input div_state_type s, input logic lead,
                                              input logic [8:0] d);
      div_state_type r;
      logic [9:0]    trial;
      logic          inbit;
      r = s;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
         inbit = (j == 0) ? lead : 1'b0;
         trial = {r.rem, inbit};
         if (trial >= {1'b0, d}) begin
            trial = trial - {1'b0, d};
            r.quo = {r.quo[7:0], 1'b1};
         end else begin
            r.quo = {r.quo[7:0], 1'b0};
         end
         r.rem = trial[8:0];
      end
      return r;
   endfunction

   div_state_type st_in [3];
   div_state_type st_ff [3];
   div_state_type init;
   logic [8:0]    den_ff [2];

   // The upper bits of num start as the remainder, which stays below den.
   always_comb begin
      init.rem = {1'b0, num[8:1]};
      init.quo = '0;
      st_in[0] = div_group(init, num[0], den);
      st_in[1] = div_group(st_ff[0], 1'b0, den_ff[0]);
      st_in[2] = div_group(st_ff[1], 1'b0, den_ff[1]);
   end

   // Stage registers; the divisor travels with its partial remainder.
   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         st_ff[0]  <= st_in[0];
         den_ff[0] <= den;
      end
      if (stage_load[1]) begin
         st_ff[1]  <= st_in[1];
         den_ff[1] <= den_ff[0];
      end
      if (stage_load[2]) begin
         st_ff[2] <= st_in[2];
      end
   end

   assign quo = st_ff[2].quo;

endmodule

// File: hw/rtl/ftbg_sprite_line.sv
// Two-stage texel modulation, semi-transparent blend and line blend path.
module ftbg_sprite_line (
   input  logic               clock,
   input  logic [1:0]         stage_load,
   input  ftbg_pkg::frag_type frag,
   output logic [14:0]        pix,
   output logic               we
);
   import ftbg_pkg::*;

   // Modulated channel: min(31, (t5 * m + 52) >> 7).
   function automatic logic [4:0] modulate(input logic [4:0] t5, input logic [7:0] m);
      logic [12:0] prod;
      logic [5:0]  v;
      prod = {5'b0, m} * {8'b0, t5};
      prod = prod + ROUND_K;
      v = prod[12:7];
      return (v > {1'b0, CH_MAX}) ? CH_MAX : v[4:0];
   endfunction

   // Half blend of the replicated destination with an 8-bit color.
   // The sum never passes 510, so the channel stays within 31.
   function automatic logic [4:0] blend(input logic [4:0] d5, input logic [7:0] f8);
      logic [8:0] sum;
      sum = {1'b0, d5, d5[4:2]} + {1'b0, f8};
      return sum[8:4];
   endfunction

   logic [7:0]  mods [3];
   logic [4:0]  m_in [3];
   logic [4:0]  m_ff [3];
   logic [4:0]  line_in [3];
   logic [4:0]  line_ff [3];
   logic [1:0]  func_ff;
   logic        tex_zero_ff;
   logic        blend_en_ff;
   logic [14:0] dest_ff;
   logic [14:0] pix_in;
   logic        we_in;
   logic [14:0] pix_ff;
   logic        we_ff;
   logic [14:0] semi_pix;
   logic [14:0] mod_pix;
   logic [14:0] line_pix;

   // First stage: per-channel modulation products and the line blend.
   always_comb begin
      mods[0] = frag.mod_r;
      mods[1] = frag.mod_g;
      mods[2] = frag.mod_b;
      for (int c = 0; c < 3; c++) begin
         m_in[c]    = modulate(frag.tex[5*c +: 5], mods[c]);
         line_in[c] = blend(frag.dest[5*c +: 5], mods[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         m_ff        <= m_in;
         line_ff     <= line_in;
         func_ff     <= frag.func;
         tex_zero_ff <= (frag.tex == '0);
         blend_en_ff <= frag.semi && frag.tex[STP_POS];
         dest_ff     <= frag.dest;
      end
   end

   // Second stage: optional semi-transparent blend and the choice of operation.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         semi_pix[5*c +: 5] = blend(dest_ff[5*c +: 5], {m_ff[c], 3'b000});
         mod_pix[5*c +: 5]  = m_ff[c];
         line_pix[5*c +: 5] = line_ff[c];
      end
      pix_in = '0;
      we_in  = 1'b0;
      unique case (func_ff)
         FUNC_SPRITE: begin
            if (!tex_zero_ff) begin
               pix_in = blend_en_ff ? semi_pix : mod_pix;
               we_in  = 1'b1;
            end
         end
         FUNC_LINE: begin
            pix_in = line_pix;
            we_in  = 1'b1;
         end
         default: begin
            pix_in = '0;
            we_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         pix_ff <= pix_in;
         we_ff  <= we_in;
      end
   end

   assign pix = pix_ff;
   assign we  = we_ff;

endmodule

// File: hw/rtl/ftbg_gouraud.sv
// Two-stage bilinear interpolation of the fixed corner colors.
module ftbg_gouraud (
   input  logic        clock,
   input  logic [1:0]  stage_load,
   input  logic [8:0]  fx,
   input  logic [8:0]  fy,
   output logic [14:0] pix
);
   import ftbg_pkg::*;

   // Linear mix a * (256 - f) + b * f; for f up to 256 the result never exceeds 65280.
   function automatic logic [15:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] f);
      logic [8:0]  wf;
      logic [16:0] sum;
      wf  = FRAC_ONE - f;
      sum = {9'b0, a} * {8'b0, wf} + {9'b0, b} * {8'b0, f};
      return sum[15:0];
   endfunction

   logic [15:0]        top_in [3];
   logic [15:0]        bot_in [3];
   logic [15:0]        top_ff [3];
   logic [15:0]        bot_ff [3];
   logic [8:0]         fy_ff;
   logic [15:0]        top2_ff [3];
   logic signed [16:0] diff [3];
   logic signed [26:0] prod_in [3];
   logic signed [26:0] prod_ff [3];
   logic signed [27:0] acc [3];

   // Horizontal mix of the top and bottom corner pairs.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         top_in[c] = lerp(CORNER[c][0], CORNER[c][1], fx);
         bot_in[c] = lerp(CORNER[c][2], CORNER[c][3], fx);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         fy_ff  <= fy;
      end
   end

   // Vertical mix as top * 256 + (bottom - top) * fy; the product is registered.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c]    = $signed({1'b0, bot_ff[c]}) - $signed({1'b0, top_ff[c]});
         prod_in[c] = diff[c] * $signed({1'b0, fy_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         top2_ff <= top_ff;
         prod_ff <= prod_in;
      end
   end

   // The sum is the exact nonnegative 24-bit value; bits 23:19 give the 5-bit channel.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = $signed({4'b0, top2_ff[c], 8'b0}) + prod_ff[c];
         pix[5*c +: 5] = acc[c][23:19];
      end
   end

endmodule

// File: test/tb_fragment_texture_blend_gouraud_core.sv
// Self-checking testbench of the fragment texture, blend and gouraud core.
`timescale 1ns / 1ps

module tb_fragment_texture_blend_gouraud_core;
   import ftbg_pkg::*;

   // The func code that selects no operation.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // Cycles without any beat on either channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // Random fragments in each pressure phase.
   localparam int PHASE_BEATS = 100;

   // One fragment as it sits on the request channel.
   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] tex;
      logic [7:0]  mod_r;
      logic [7:0]  mod_g;
      logic [7:0]  mod_b;
      logic        semi;
      logic [14:0] dest;
      logic [8:0]  pos_x;
      logic [8:0]  pos_y;
      logic [8:0]  quad_w;
      logic [8:0]  quad_h;
   } fragment_type;

   // One response beat: the new pixel and its write strobe.
   typedef struct packed {
      logic [14:0] pixel;
      logic        we;
   } pixel_result_type;

   // Predicts the pixel of every accepted fragment and checks responses in order.
   class fragment_scoreboard;
      pixel_result_type expected_pixels[$];
      int               mismatch_count = 0;
      int               checked_count  = 0;

      // Half blend of a replicated 5-bit destination channel with an 8-bit color.
      function automatic logic [4:0] blend_channel(logic [4:0] d5, logic [7:0] f8);
         int unsigned v;
         v = ((({3'b000, d5} << 3) | (d5 >> 2)) + f8) >> 4;
         return (v > CH_MAX) ? CH_MAX : v[4:0];
      endfunction

      function automatic pixel_result_type predict_pixel(fragment_type f);
         pixel_result_type r;
         logic [4:0]       ch [3];
         logic [4:0]       t5;
         logic [4:0]       d5;
         logic [7:0]       m8;
         int unsigned      v, fx, fy, top, bot, c8;
         r.pixel = '0;
         r.we    = 1'b0;
         case (f.func)
            FUNC_SPRITE: begin
               if (f.tex != 16'h0000) begin
                  for (int i = 0; i < 3; i++) begin
                     t5 = f.tex[5*i +: 5];
                     d5 = f.dest[5*i +: 5];
                     m8 = (i == 0) ? f.mod_r : (i == 1) ? f.mod_g : f.mod_b;
                     v = (t5 * m8 + ROUND_K) >> 7;
                     ch[i] = (v > CH_MAX) ? CH_MAX : v[4:0];
                     // Semi-transparent texels are averaged with the framebuffer.
                     if (f.semi && f.tex[STP_POS])
                        ch[i] = blend_channel(d5, {ch[i], 3'b000});
                     r.pixel[5*i +: 5] = ch[i];
                  end
                  r.we = 1'b1;
               end
            end
            FUNC_LINE: begin
               for (int i = 0; i < 3; i++) begin
                  m8 = (i == 0) ? f.mod_r : (i == 1) ? f.mod_g : f.mod_b;
                  r.pixel[5*i +: 5] = blend_channel(f.dest[5*i +: 5], m8);
               end
               r.we = 1'b1;
            end
            FUNC_GOURAUD: begin
               // Only positions inside the quad are drawn.
               if (f.pos_x < f.quad_w && f.pos_y < f.quad_h) begin
                  fx = (f.quad_w > 1) ? (f.pos_x * FRAC_ONE) / (f.quad_w - 1) : 0;
                  fy = (f.quad_h > 1) ? (f.pos_y * FRAC_ONE) / (f.quad_h - 1) : 0;
                  for (int i = 0; i < 3; i++) begin
                     top = CORNER[i][0] * (FRAC_ONE - fx) + CORNER[i][1] * fx;
                     bot = CORNER[i][2] * (FRAC_ONE - fx) + CORNER[i][3] * fx;
                     c8  = (top * (FRAC_ONE - fy) + bot * fy) >> 16;
                     r.pixel[5*i +: 5] = c8[7:3];
                  end
                  r.we = 1'b1;
               end
            end
            default: begin
            end
         endcase
         return r;
      endfunction

      function void note_fragment(fragment_type f);
         expected_pixels.push_back(predict_pixel(f));
      endfunction

      function void check_result(logic [14:0] pixel, logic we);
         pixel_result_type e;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected response beat, pixel_out %h write_enable %b",
                     $time, pixel, we);
            mismatch_count++;
            return;
         end
         e = expected_pixels.pop_front();
         checked_count++;
         if (pixel !== e.pixel) begin
            $display("%0t: pixel_out mismatch, expected %h, actual %h", $time, e.pixel, pixel);
            mismatch_count++;
         end
         if (we !== e.we) begin
            $display("%0t: write_enable mismatch, expected %b, actual %b", $time, e.we, we);
            mismatch_count++;
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   fragment_type  req_beat = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [14:0]   rsp_pixel_out;
   logic          rsp_write_enable;

   int            idle_pct  = 0;
   int            stall_pct = 0;
   int            idle_cycles = 0;
   int            func_count [4] = '{0, 0, 0, 0};
   fragment_scoreboard board = new();

   fragment_texture_blend_gouraud_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_beat.func),
      .req_texel_color  (req_beat.tex),
      .req_mod_r        (req_beat.mod_r),
      .req_mod_g        (req_beat.mod_g),
      .req_mod_b        (req_beat.mod_b),
      .req_semi_enable  (req_beat.semi),
      .req_dest_pixel   (req_beat.dest),
      .req_pos_x        (req_beat.pos_x),
      .req_pos_y        (req_beat.pos_y),
      .req_quad_w       (req_beat.quad_w),
      .req_quad_h       (req_beat.quad_h),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_write_enable (rsp_write_enable)
   );

   // Free-running 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The response side stalls at random with the current phase's rate.
   always @(negedge clock) begin
      rsp_stall = !reset && ($urandom_range(99) < stall_pct);
   end

   // Both channels are observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_fragment(req_beat);
            func_count[req_beat.func]++;
         end
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_pixel_out, rsp_write_enable);
      end
   end

   // A hung handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic fragment_type make_fragment(logic [1:0] func, logic [15:0] tex,
                                                  logic [7:0] mr, logic [7:0] mg,
                                                  logic [7:0] mb, logic semi,
                                                  logic [14:0] dest, logic [8:0] px,
                                                  logic [8:0] py, logic [8:0] qw,
                                                  logic [8:0] qh);
      fragment_type f;
      f = '{func, tex, mr, mg, mb, semi, dest, px, py, qw, qh};
      return f;
   endfunction

   // Random fragment: every field is random, then shaped to hit the interesting cases.
   function automatic fragment_type random_fragment();
      fragment_type f;
      int           pick;
      f.tex    = 16'($urandom);
      f.mod_r  = 8'($urandom);
      f.mod_g  = 8'($urandom);
      f.mod_b  = 8'($urandom);
      f.semi   = 1'($urandom);
      f.dest   = 15'($urandom);
      f.pos_x  = 9'($urandom);
      f.pos_y  = 9'($urandom);
      f.quad_w = 9'($urandom);
      f.quad_h = 9'($urandom);
      pick = $urandom_range(99);
      f.func = (pick < 35) ? FUNC_SPRITE : (pick < 60) ? FUNC_LINE :
               (pick < 95) ? FUNC_GOURAUD : FUNC_UNUSED;
      if (f.func == FUNC_SPRITE) begin
         pick = $urandom_range(19);
         if (pick == 0)
            f.tex = 16'h0000;
         else if (pick == 1)
            f.tex = 16'h8000;
      end
      if (f.func == FUNC_GOURAUD) begin
         // Mostly small quads with positions inside; sometimes full range.
         if ($urandom_range(9) < 8) begin
            f.quad_w = 9'($urandom_range(24));
            f.quad_h = 9'($urandom_range(24));
         end
         if ($urandom_range(99) < 85 && f.quad_w != 0 && f.quad_h != 0) begin
            f.pos_x = 9'($urandom_range(f.quad_w - 1));
            f.pos_y = 9'($urandom_range(f.quad_h - 1));
         end
      end
      return f;
   endfunction

   // Offers one fragment after the phase's random gap and waits until it is taken.
   task automatic send_fragment(input fragment_type f);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_beat  = f;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   initial begin
      int mode_idle [4];
      int mode_stall [4];
      mode_idle  = '{0, 59, 0, 28};
      mode_stall = '{0, 0, 59, 28};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed fragments: extremes of the fields and each special case.
      // Transparent texel, then an all-black texel carrying only the flag.
      send_fragment(make_fragment(FUNC_SPRITE, 16'h0000, 8'hff, 8'hff, 8'hff, 1'b1,
                                  15'h7fff, 9'd0, 9'd0, 9'd0, 9'd0));
      send_fragment(make_fragment(FUNC_SPRITE, 16'h8000, 8'hff, 8'hff, 8'hff, 1'b1,
                                  15'h7fff, 9'd0, 9'd0, 9'd0, 9'd0));
      // Full modulation saturates the channel ceiling.
      send_fragment(make_fragment(FUNC_SPRITE, 16'h7fff, 8'hff, 8'hff, 8'hff, 1'b0,
                                  15'h0000, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff));
      send_fragment(make_fragment(FUNC_SPRITE, 16'hffff, 8'hff, 8'hff, 8'hff, 1'b0,
                                  15'h7fff, 9'd0, 9'd0, 9'd0, 9'd0));
      send_fragment(make_fragment(FUNC_SPRITE, 16'hffff, 8'hff, 8'hff, 8'hff, 1'b1,
                                  15'h7fff, 9'd0, 9'd0, 9'd0, 9'd0));
      send_fragment(make_fragment(FUNC_SPRITE, 16'hffff, 8'h80, 8'h40, 8'h20, 1'b1,
                                  15'h0000, 9'd0, 9'd0, 9'd0, 9'd0));
      send_fragment(make_fragment(FUNC_SPRITE, 16'h7fff, 8'h00, 8'h00, 8'h00, 1'b1,
                                  15'h7fff, 9'd0, 9'd0, 9'd0, 9'd0));
      send_fragment(make_fragment(FUNC_SPRITE, 16'h0001, 8'h01, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd0, 9'd0, 9'd0, 9'd0));
      // Line blends at both extremes of destination and fill.
      send_fragment(make_fragment(FUNC_LINE, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd0, 9'd0, 9'd0, 9'd0));
      send_fragment(make_fragment(FUNC_LINE, 16'hffff, 8'hff, 8'hff, 8'hff, 1'b1,
                                  15'h7fff, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff));
      send_fragment(make_fragment(FUNC_LINE, 16'h0000, 8'hff, 8'h00, 8'h80, 1'b0,
                                  15'h03e0, 9'd0, 9'd0, 9'd0, 9'd0));
      // Gouraud: zero width or height, a single pixel, the far corner, out of range.
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd0, 9'd0, 9'd0, 9'd5));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd0, 9'd0, 9'd5, 9'd0));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd0, 9'd0, 9'd1, 9'd1));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd0, 9'd0, 9'd2, 9'd2));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd1, 9'd1, 9'd2, 9'd2));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'hffff, 8'hff, 8'hff, 8'hff, 1'b1,
                                  15'h7fff, 9'd510, 9'd510, 9'd511, 9'd511));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd0, 9'd510, 9'd511, 9'd511));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd7, 9'd3, 9'd7, 9'd9));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'd3, 9'd9, 9'd7, 9'd9));
      send_fragment(make_fragment(FUNC_GOURAUD, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0,
                                  15'h0000, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff));
      // The unused operation code draws nothing.
      send_fragment(make_fragment(FUNC_UNUSED, 16'hffff, 8'hff, 8'hff, 8'hff, 1'b1,
                                  15'h7fff, 9'd1, 9'd1, 9'd4, 9'd4));

      // Random fragments, cycling twice through the four pressure modes.
      for (int phase = 0; phase < 8; phase++) begin
         idle_pct  = mode_idle[phase % 4];
         stall_pct = mode_stall[phase % 4];
         for (int n = 0; n < PHASE_BEATS; n++)
            send_fragment(random_fragment());
      end

      @(negedge clock);
      req_valid = 1'b0;

      // Drain, then allow the pipeline depth for any stray beat to show up.
      while (board.expected_pixels.size() != 0)
         @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);

      $display("Run covered %0d sprite, %0d line, %0d gouraud and %0d unused-op fragments,",
               func_count[0], func_count[1], func_count[2], func_count[3]);
      $display("with free, sender-gap, receiver-stall and mixed pressure; %0d beats checked.",
               board.checked_count);
      if (board.mismatch_count == 0 && board.expected_pixels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
